// ----- rtl/modbus_rtu_frame_delimiter_core_assert.svh -----
// Assertion macros for the frame delimiter RTL.
`ifndef MODBUS_RTU_FRAME_DELIMITER_CORE_ASSERT_SVH
`define MODBUS_RTU_FRAME_DELIMITER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define MRFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define MRFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MRFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define MRFD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/mrfd_pkg.sv -----
package mrfd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 9;

    // Function codes
    localparam logic [BYTE_W-1:0] FC_READ_COILS      = 8'h01;
    localparam logic [BYTE_W-1:0] FC_READ_DISCRETE   = 8'h02;
    localparam logic [BYTE_W-1:0] FC_READ_HOLDING    = 8'h03;
    localparam logic [BYTE_W-1:0] FC_READ_INPUT      = 8'h04;
    localparam logic [BYTE_W-1:0] FC_WRITE_COIL      = 8'h05;
    localparam logic [BYTE_W-1:0] FC_WRITE_REG       = 8'h06;
    localparam logic [BYTE_W-1:0] FC_READ_EXC_STATUS = 8'h07;
    localparam logic [BYTE_W-1:0] FC_DIAGNOSTICS     = 8'h08;
    localparam logic [BYTE_W-1:0] FC_COMM_EVENT_CTR  = 8'h0B;
    localparam logic [BYTE_W-1:0] FC_COMM_EVENT_LOG  = 8'h0C;
    localparam logic [BYTE_W-1:0] FC_WRITE_COILS     = 8'h0F;
    localparam logic [BYTE_W-1:0] FC_WRITE_REGS      = 8'h10;
    localparam logic [BYTE_W-1:0] FC_REPORT_ID       = 8'h11;
    localparam logic [BYTE_W-1:0] FC_MASK_WRITE      = 8'h16;

    // Bit 7 of a response code marks an exception
    localparam int unsigned EXC_BIT = 7;

    // Byte positions
    localparam logic [POS_W-1:0] POS_CODE      = 9'd1;
    localparam logic [POS_W-1:0] POS_CNT_QUERY = 9'd6;
    localparam logic [POS_W-1:0] POS_CNT_RESP  = 9'd2;

    // Frame lengths including CRC
    localparam logic [3:0] LEN_SHORT     = 4'd4;
    localparam logic [3:0] LEN_EXC       = 4'd5;
    localparam logic [3:0] LEN_FIXED     = 4'd8;
    localparam logic [3:0] LEN_MASK      = 4'd10;
    localparam logic [POS_W-1:0] LEN_HDR_QUERY_CNT = 9'd9;
    localparam logic [POS_W-1:0] LEN_HDR_RESP_CNT  = 9'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              from_slave;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0] fwd_byte;
        logic              to_slave;
        logic [POS_W-1:0]  byte_index;
        logic              last_of_frame;
        logic [POS_W-1:0]  total_length;
        logic              is_exception;
        logic              status;
    } t_out;

    typedef struct packed {
        logic       supported;
        logic       counted;
        logic [3:0] len;
    } t_len_info;

    function automatic t_len_info length_for_code(input logic side,
                                                  input logic [BYTE_W-1:0] code);
        t_len_info info;
        info = '{supported: 1'b1, counted: 1'b0, len: 4'd0};
        if (!side) begin
            unique case (code)
                FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
                FC_WRITE_COIL, FC_WRITE_REG, FC_DIAGNOSTICS: info.len = LEN_FIXED;
                FC_READ_EXC_STATUS, FC_COMM_EVENT_CTR, FC_COMM_EVENT_LOG,
                FC_REPORT_ID:                                info.len = LEN_SHORT;
                FC_WRITE_COILS, FC_WRITE_REGS:               info.counted = 1'b1;
                FC_MASK_WRITE:                               info.len = LEN_MASK;
                default:                                     info.supported = 1'b0;
            endcase
        end else if (code[EXC_BIT]) begin
            info.len = LEN_EXC;
        end else begin
            unique case (code)
                FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
                FC_COMM_EVENT_LOG, FC_REPORT_ID:             info.counted = 1'b1;
                FC_WRITE_COIL, FC_WRITE_REG, FC_DIAGNOSTICS, FC_COMM_EVENT_CTR,
                FC_WRITE_COILS, FC_WRITE_REGS:               info.len = LEN_FIXED;
                FC_READ_EXC_STATUS:                          info.len = LEN_EXC;
                FC_MASK_WRITE:                               info.len = LEN_MASK;
                default:                                     info.supported = 1'b0;
            endcase
        end
        return info;
    endfunction

endpackage

// ----- rtl/modbus_rtu_frame_delimiter_core.sv -----
// Modbus RTU frame delimiter.
// Input channel (i_in_valid / o_in_ready / i_in_data): one received byte per
// transfer, tagged with the side it came from. Output channel (o_out_valid /
// i_out_ready / o_out_data): one result per byte, carrying the byte, the side
// to forward it to, its index in the frame, a last-of-frame flag, the frame
// length once known, an exception flag and an unsupported-code status.
// A transferred byte lands in the input register and moves on into the result
// register, which drives the output, once that register is free. Throughput: one
// byte per cycle while the receiver takes results; each byte needs only a code
// lookup and a short compare/add.
// Reset (synchronous, active low) empties both register stages and closes any
// open frame, so the next byte is taken as an address byte.
// Receiver stall: the result register holds its item; the input register can
// still take one more byte, after which o_in_ready drops until the output
// drains. Frame state advances only when a byte moves into the result register.
module modbus_rtu_frame_delimiter_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mrfd_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mrfd_pkg::t_out o_out_data
);

    logic           r_s1_valid;
    mrfd_pkg::t_in  r_s1_data;
    logic           r_out_valid;
    mrfd_pkg::t_out r_out_data;

    logic           out_free;
    logic           s1_move;
    mrfd_pkg::t_out result;

    // Result register can load when empty or being drained this cycle.
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || s1_move;

    mrfd_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (s1_move),
        .i_item    (r_s1_data),
        .o_result  (result)
    );

    // Control: valid flags of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= s1_move;
            end
        end
    end

    // Payload: load on transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_data <= i_in_data;
        end
        if (s1_move) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/mrfd_parse.sv -----
`include "modbus_rtu_frame_delimiter_core_assert.svh"

module mrfd_parse (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_advance,
    input  mrfd_pkg::t_in i_item,
    output mrfd_pkg::t_out o_result
);

    logic                         r_in_frame;
    logic                         r_side;
    logic [mrfd_pkg::POS_W-1:0]   r_pos;
    logic [mrfd_pkg::BYTE_W-1:0]  r_code;
    logic [mrfd_pkg::POS_W-1:0]   r_exp;

    logic                         n_in_frame;
    logic                         n_side;
    logic [mrfd_pkg::POS_W-1:0]   n_pos;
    logic [mrfd_pkg::BYTE_W-1:0]  n_code;
    logic [mrfd_pkg::POS_W-1:0]   n_exp;

    logic [mrfd_pkg::POS_W-1:0]   idx;
    logic [mrfd_pkg::POS_W-1:0]   exp_cur;
    logic [mrfd_pkg::POS_W:0]     idx_plus;
    logic                         last;
    logic                         status;
    mrfd_pkg::t_len_info          info;

    always_comb begin
        // A byte with no frame open starts a new one and latches its side.
        n_side  = r_in_frame ? r_side : i_item.from_slave;
        idx     = r_in_frame ? r_pos : '0;
        n_code  = r_in_frame ? r_code : '0;
        exp_cur = r_in_frame ? r_exp : '0;
        n_exp   = exp_cur;
        status  = 1'b0;
        last    = 1'b0;
        info    = mrfd_pkg::length_for_code(n_side, i_item.rx_byte);

        if (idx == mrfd_pkg::POS_CODE) begin
            n_code = i_item.rx_byte;
            if (!info.supported) begin
                status = 1'b1;
                last   = 1'b1;
                n_exp  = '0;
            end else begin
                n_exp = info.counted ? '0 : {5'd0, info.len};
            end
        end else if (idx >= mrfd_pkg::POS_CNT_RESP && exp_cur == '0) begin
            if (!n_side && idx == mrfd_pkg::POS_CNT_QUERY) begin
                n_exp = mrfd_pkg::LEN_HDR_QUERY_CNT + {1'b0, i_item.rx_byte};
            end else if (n_side && idx == mrfd_pkg::POS_CNT_RESP) begin
                n_exp = mrfd_pkg::LEN_HDR_RESP_CNT + {1'b0, i_item.rx_byte};
            end
        end

        idx_plus = {1'b0, idx} + 10'd1;
        if (n_exp != '0 && idx_plus >= {1'b0, n_exp}) begin
            last = 1'b1;
        end

        n_in_frame = !last;
        n_pos      = last ? '0 : idx_plus[mrfd_pkg::POS_W-1:0];

        o_result.fwd_byte      = i_item.rx_byte;
        o_result.to_slave      = !n_side;
        o_result.byte_index    = idx;
        o_result.last_of_frame = last;
        o_result.total_length  = n_exp;
        o_result.is_exception  = (idx != '0) && n_side && n_code[mrfd_pkg::EXC_BIT];
        o_result.status        = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_side     <= 1'b0;
            r_pos      <= '0;
            r_code     <= '0;
            r_exp      <= '0;
        end else if (i_advance) begin
            r_in_frame <= n_in_frame;
            r_side     <= n_side;
            r_pos      <= n_pos;
            r_code     <= n_code;
            r_exp      <= n_exp;
        end
    end

    `MRFD_ASSERT(a_last_closes, i_clk, i_rst_n, i_advance && o_result.last_of_frame |=> !r_in_frame, "frame still open after last byte")
    `MRFD_ASSERT(a_pos_steps, i_clk, i_rst_n, i_advance && !o_result.last_of_frame |=> r_in_frame && r_pos == $past(o_result.byte_index) + 9'd1, "position did not advance by one")
    `MRFD_ASSERT(a_pos_in_len, i_clk, i_rst_n, r_in_frame && r_exp != '0 |-> r_pos < r_exp, "position ran past frame length")
    `MRFD_ASSERT_ALWAYS(a_status_ends, i_clk, o_result.status |-> o_result.last_of_frame && o_result.total_length == '0, "unsupported code did not end frame")

endmodule

// ----- tb/modbus_rtu_frame_delimiter_core_tb.sv -----
module modbus_rtu_frame_delimiter_core_tb;

    localparam int CYCLE_LIMIT      = 100_000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int LEN_FROM_COUNT   = 0;
    localparam int LEN_UNKNOWN_CODE = -1;

    // File record codes: valid on the bus but not handled by the block
    localparam logic [mrfd_pkg::BYTE_W-1:0] FC_READ_FILE  = 8'h14;
    localparam logic [mrfd_pkg::BYTE_W-1:0] FC_WRITE_FILE = 8'h15;

    logic           i_clk     = 1'b0;
    logic           i_rst_n   = 1'b0;
    logic           in_valid  = 1'b0;
    mrfd_pkg::t_in  in_data   = '0;
    logic           out_ready = 1'b0;
    logic           o_in_ready;
    logic           o_out_valid;
    mrfd_pkg::t_out o_out_data;

    // Frame tracking state of the predictor
    logic                          frm_open = 1'b0;
    logic                          frm_side = 1'b0;
    logic [mrfd_pkg::POS_W-1:0]    frm_pos  = '0;
    logic [mrfd_pkg::BYTE_W-1:0]   frm_code = '0;
    logic [mrfd_pkg::POS_W-1:0]    frm_len  = '0;

    mrfd_pkg::t_out pending_results[$];
    int   send_idle_pct  = 0;
    int   recv_idle_pct  = 0;
    int   bytes_sent     = 0;
    int   results_seen   = 0;
    int   mismatch_count = 0;
    int   cycle_count    = 0;

    modbus_rtu_frame_delimiter_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Frame length with CRC for a function code, or a marker when a byte
    // count decides it or the code is not handled.
    function automatic int frame_length_for(input logic side,
                                            input logic [mrfd_pkg::BYTE_W-1:0] code);
        if (side && code[mrfd_pkg::EXC_BIT]) return int'(mrfd_pkg::LEN_EXC);
        unique case (code)
            mrfd_pkg::FC_READ_COILS, mrfd_pkg::FC_READ_DISCRETE,
            mrfd_pkg::FC_READ_HOLDING, mrfd_pkg::FC_READ_INPUT:
                return side ? LEN_FROM_COUNT : int'(mrfd_pkg::LEN_FIXED);
            mrfd_pkg::FC_WRITE_COIL, mrfd_pkg::FC_WRITE_REG, mrfd_pkg::FC_DIAGNOSTICS:
                return int'(mrfd_pkg::LEN_FIXED);
            mrfd_pkg::FC_READ_EXC_STATUS:
                return side ? int'(mrfd_pkg::LEN_EXC) : int'(mrfd_pkg::LEN_SHORT);
            mrfd_pkg::FC_COMM_EVENT_CTR:
                return side ? int'(mrfd_pkg::LEN_FIXED) : int'(mrfd_pkg::LEN_SHORT);
            mrfd_pkg::FC_COMM_EVENT_LOG, mrfd_pkg::FC_REPORT_ID:
                return side ? LEN_FROM_COUNT : int'(mrfd_pkg::LEN_SHORT);
            mrfd_pkg::FC_WRITE_COILS, mrfd_pkg::FC_WRITE_REGS:
                return side ? int'(mrfd_pkg::LEN_FIXED) : LEN_FROM_COUNT;
            mrfd_pkg::FC_MASK_WRITE:
                return int'(mrfd_pkg::LEN_MASK);
            default:
                return LEN_UNKNOWN_CODE;
        endcase
    endfunction

    // Advance the frame tracker by one byte and return the echo it causes.
    function automatic mrfd_pkg::t_out delimit_byte(input mrfd_pkg::t_in item);
        mrfd_pkg::t_out             res;
        int                         code_len;
        logic [mrfd_pkg::POS_W-1:0] idx;
        if (!frm_open) begin
            frm_open = 1'b1;
            frm_side = item.from_slave;
            frm_pos  = '0;
            frm_code = '0;
            frm_len  = '0;
        end
        idx = frm_pos;
        res = '0;
        res.fwd_byte   = item.rx_byte;
        res.to_slave   = ~frm_side;
        res.byte_index = idx;
        if (idx == mrfd_pkg::POS_CODE) begin
            code_len = frame_length_for(frm_side, item.rx_byte);
            frm_code = item.rx_byte;
            if (code_len == LEN_UNKNOWN_CODE) begin
                res.status        = 1'b1;
                res.last_of_frame = 1'b1;
                frm_len           = '0;
            end else begin
                frm_len = code_len[mrfd_pkg::POS_W-1:0];
            end
        end else if (idx > mrfd_pkg::POS_CODE && frm_len == 0) begin
            // pick up the byte count where the length depends on it
            if (!frm_side && idx == mrfd_pkg::POS_CNT_QUERY)
                frm_len = mrfd_pkg::LEN_HDR_QUERY_CNT + {1'b0, item.rx_byte};
            else if (frm_side && idx == mrfd_pkg::POS_CNT_RESP)
                frm_len = mrfd_pkg::LEN_HDR_RESP_CNT + {1'b0, item.rx_byte};
        end
        if (frm_len != 0 && int'(idx) + 1 >= int'(frm_len)) res.last_of_frame = 1'b1;
        res.total_length = frm_len;
        res.is_exception = (idx >= mrfd_pkg::POS_CODE) && frm_side
                           && frm_code[mrfd_pkg::EXC_BIT];
        if (res.last_of_frame) begin
            frm_open = 1'b0;
            frm_pos  = '0;
        end else begin
            frm_pos = idx + 9'd1;
        end
        return res;
    endfunction

    function automatic mrfd_pkg::t_in byte_in(input logic [mrfd_pkg::BYTE_W-1:0] b,
                                              input logic side);
        return '{rx_byte: b, from_slave: side};
    endfunction

    function automatic string fmt_result(input mrfd_pkg::t_out r);
        return $sformatf("byte 0x%02h to_slave %0b idx %0d last %0b len %0d exc %0b status %0b",
                         r.fwd_byte, r.to_slave, r.byte_index, r.last_of_frame,
                         r.total_length, r.is_exception, r.status);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch: %s", msg);
    endtask

    task automatic compare_result(input mrfd_pkg::t_out got, input mrfd_pkg::t_out want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: got %s; want %s",
                                      results_seen, fmt_result(got), fmt_result(want)));
    endtask

    // Result side: check each transfer, then randomize ready for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && out_ready) begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                else
                    compare_result(o_out_data, pending_results.pop_front());
                results_seen++;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one byte, hold it until the transfer, then record its echo.
    task automatic send_byte(input mrfd_pkg::t_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(delimit_byte(item));
        bytes_sent++;
    endtask

    task automatic wait_for_drain();
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Send one frame with random content. A nonzero cut below the frame length stops
    // early; the frame is then padded with random bytes until the tracker closes it.
    task automatic send_frame(input logic side, input logic [mrfd_pkg::BYTE_W-1:0] code,
                              input int cnt, input int cut);
        int            code_len;
        int            frame_len;
        int            cnt_pos;
        mrfd_pkg::t_in item;
        code_len = frame_length_for(side, code);
        cnt_pos  = int'(side ? mrfd_pkg::POS_CNT_RESP : mrfd_pkg::POS_CNT_QUERY);
        if (code_len == LEN_UNKNOWN_CODE)
            frame_len = int'(mrfd_pkg::POS_CODE) + 1;
        else if (code_len == LEN_FROM_COUNT)
            frame_len = int'(side ? mrfd_pkg::LEN_HDR_RESP_CNT
                                  : mrfd_pkg::LEN_HDR_QUERY_CNT) + cnt;
        else
            frame_len = code_len;
        if (cut > 0 && cut < frame_len) frame_len = cut;
        for (int i = 0; i < frame_len; i++) begin
            item = byte_in(8'($urandom_range(255)),
                           (i == 0) ? side : 1'($urandom_range(1)));
            if (i == int'(mrfd_pkg::POS_CODE))
                item.rx_byte = code;
            else if (code_len == LEN_FROM_COUNT && i == cnt_pos)
                item.rx_byte = cnt[mrfd_pkg::BYTE_W-1:0];
            send_byte(item);
        end
        while (frm_open) send_byte(byte_in(8'($urandom_range(255)), 1'($urandom_range(1))));
    endtask

    task automatic send_random_frame();
        logic                        side;
        logic [mrfd_pkg::BYTE_W-1:0] code;
        int                          cnt;
        int                          pick;
        side = 1'($urandom_range(1));
        cnt  = ($urandom_range(9) == 0) ? int'($urandom_range(40)) : int'($urandom_range(8));
        pick = int'($urandom_range(99));
        if (pick < 60 || pick >= 85) begin
            do code = 8'($urandom_range(mrfd_pkg::FC_MASK_WRITE));
            while (frame_length_for(side, code) == LEN_UNKNOWN_CODE);
            // broken frames may be cut short and run into random bytes
            send_frame(side, code, cnt, (pick >= 85) ? int'($urandom_range(1, 6)) : 0);
        end else if (pick < 70) begin
            code = 8'($urandom_range(255));
            code[mrfd_pkg::EXC_BIT] = 1'b1;
            send_frame(1'b1, code, cnt, 0);
        end else begin
            send_frame(side, 8'($urandom_range(255)), cnt, 0);
        end
    endtask

    // Some later bytes carry the wrong side; the frame keeps the side of byte 0.
    task automatic test_side_latching();
        send_byte(byte_in(8'h00, 1'b0));
        send_byte(byte_in(mrfd_pkg::FC_READ_EXC_STATUS, 1'b1));
        send_byte(byte_in(8'hFF, 1'b1));
        send_byte(byte_in(8'h00, 1'b0));
    endtask

    task automatic test_exception_response();
        send_byte(byte_in(8'hFF, 1'b1));
        send_byte(byte_in(mrfd_pkg::FC_READ_HOLDING | (8'h1 << mrfd_pkg::EXC_BIT), 1'b1));
        send_byte(byte_in(8'h02, 1'b0));
        send_byte(byte_in(8'hA5, 1'b1));
        send_byte(byte_in(8'h5A, 1'b0));
    endtask

    task automatic test_unsupported_codes();
        send_byte(byte_in(8'h01, 1'b0));
        send_byte(byte_in(FC_READ_FILE, 1'b0));
        send_byte(byte_in(8'h02, 1'b1));
        send_byte(byte_in(FC_WRITE_FILE, 1'b0));
    endtask

    task automatic test_zero_byte_count();
        send_frame(1'b1, mrfd_pkg::FC_READ_COILS, 0, 0);
        send_frame(1'b0, mrfd_pkg::FC_WRITE_COILS, 0, 0);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
        int stop_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at       = bytes_sent + n;
        while (bytes_sent < stop_at) send_random_frame();
    endtask

    // Hold the input off until every echo is back, then resume.
    task automatic test_drain_pause();
        send_random_frame();
        in_valid <= 1'b0;
        wait_for_drain();
        send_random_frame();
    endtask

    // Largest byte count: reaches the top byte index and frame length.
    task automatic test_longest_frame();
        send_frame(1'b0, mrfd_pkg::FC_WRITE_REGS, 255, 0);
    endtask

    initial begin
        send_idle_pct = 29;
        recv_idle_pct = 51;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_side_latching();
        test_exception_response();
        test_unsupported_codes();
        test_zero_byte_count();
        test_random_traffic(29, 51, 50);
        test_drain_pause();
        test_random_traffic(51, 29, 50);
        test_random_traffic(0, 0, 50);
        test_longest_frame();
        in_valid <= 1'b0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
